// ----- hw/rtl/ned_pkg.sv -----
`timescale 1ns / 1ps

package ned_pkg;

    // Width of the clamped difference magnitude that feeds the multiplier.
    localparam int unsigned MAG_W     = 21;
    // Sum of squares, saturating.
    localparam int unsigned ACC_W     = 2 * MAG_W;
    // Integer square root of the mean, and its digit-recurrence remainder.
    localparam int unsigned ROOT_W    = ACC_W / 2;
    localparam int unsigned SQ_REM_W  = ROOT_W + 2;
    // Result format: unsigned Q17.0, an integer.
    localparam int unsigned DIST_W    = 17;
    // Step counts of the divider and the root recurrence.
    localparam int unsigned DIV_STEPS = ACC_W;
    localparam int unsigned SQ_STEPS  = ROOT_W;
    localparam int unsigned CNT_W     = 6;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Input operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes.
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_MISMATCH = 1'b1;

endpackage

// ----- hw/rtl/ned_if.sv -----
`timescale 1ns / 1ps

// Input channel: one vector element per transaction.
interface ned_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   is_last;

    modport source (output valid, output op, output sample_value, output is_last, input ready);
    modport sink   (input valid, input op, input sample_value, input is_last, output ready);
endinterface

// Output channel: one distance result per transaction.
interface ned_out_if;
    import ned_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              status;

    modport source (output valid, output distance, output status, input ready);
    modport sink   (input valid, input distance, input status, output ready);
endinterface

// ----- hw/rtl/normalized_euclidean_distance_core.sv -----
`timescale 1ns / 1ps

// Normalized Euclidean distance core. A reference vector is loaded one element
// per transaction (op 0, is_last closes it, up to MAX_LENGTH elements; extra
// loads are dropped and flag the vector). Query elements (op 1) are then
// compared against it, and the query's last element yields one result:
// floor(sqrt(floor(sum of squared differences / n))) in unsigned Q17.0,
// saturated, with status 0, or distance 0 with status 1 on a length mismatch,
// an empty reference or an overflowed load. A load element leaves the core
// ready again in the next cycle. A query element steps through accept, memory
// read and difference, square and accumulate. A last query element with a
// valid length then runs the 42-step restoring divider and the 21-step
// square-root recurrence, both one step per cycle on a single shared
// subtractor, and hands the result to the output register; a mismatching last
// element goes straight to that hand-over. The output register holds a result
// while the sink stalls; a further result waits in the hand-over until it frees.
module normalized_euclidean_distance_core
    import ned_pkg::*;
#(
    parameter int MAX_LENGTH  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ned_in_if.sink    i_in,
    ned_out_if.source o_out
);

    localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int QI_W   = $clog2(2 * MAX_LENGTH);
    localparam int ALU_W  = (LEN_W + 1 > SQ_REM_W) ? LEN_W + 1 : SQ_REM_W;
    localparam int MW     = (SAMPLE_BITS + 1 > MAG_W + 1) ? SAMPLE_BITS + 1 : MAG_W + 1;
    localparam logic [QI_W-1:0]  QI_MAX  = QI_W'(2 * MAX_LENGTH - 1);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_LENGTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_state;

    // Sequencer and vector state.
    t_state                  r_state,     n_state;
    logic [LEN_W-1:0]        r_len,       n_len;
    logic                    r_restart,   n_restart;
    logic                    r_ovf,       n_ovf;
    logic [QI_W-1:0]         r_qidx,      n_qidx;
    logic [ACC_W-1:0]        r_acc,       n_acc;
    logic                    r_out_valid, n_out_valid;

    // Datapath registers.
    logic [SAMPLE_BITS-1:0]  r_smp,       n_smp;
    logic                    r_last,      n_last;
    logic                    r_add_en,    n_add_en;
    logic [MAG_W-1:0]        r_mag,       n_mag;
    logic                    r_big,       n_big;
    logic [ACC_W-1:0]        r_sq,        n_sq;
    logic [ACC_W-1:0]        r_quo,       n_quo;
    logic [LEN_W-1:0]        r_rem,       n_rem;
    logic [ROOT_W-1:0]       r_srem,      n_srem;
    logic [ROOT_W-1:0]       r_root,      n_root;
    logic [CNT_W-1:0]        r_cnt,       n_cnt;
    logic                    r_mis,       n_mis;
    logic [DIST_W-1:0]       r_out_dist,  n_out_dist;
    logic                    r_out_status, n_out_status;

    // Memory and shared unit connections.
    logic                    w_wr_en;
    logic [LEN_W-1:0]        w_eff_len;
    logic                    w_rd_en;
    logic [SAMPLE_BITS-1:0]  w_ref;
    logic [ALU_W-1:0]        w_alu_a;
    logic [ALU_W-1:0]        w_alu_b;
    logic                    w_alu_ge;
    logic [ALU_W-1:0]        w_alu_diff;

    // Difference, magnitude and sum.
    logic signed [SAMPLE_BITS:0] w_diff;
    logic [SAMPLE_BITS:0]    w_mag;
    logic [MW-1:0]           w_mag_wide;
    logic [ACC_W:0]          w_sum;
    logic [ACC_W-1:0]        w_acc_new;
    logic [LEN_W:0]          w_div_part;
    logic [SQ_REM_W-1:0]     w_sq_part;
    logic                    w_in_acc;

    assign w_in_acc  = i_in.valid && (r_state == S_IDLE);
    assign w_eff_len = r_restart ? '0 : r_len;
    assign w_wr_en   = w_in_acc && (i_in.op == OP_LOAD) && (w_eff_len < LEN_CAP);
    assign w_rd_en   = w_in_acc && (i_in.op == OP_QUERY) && (r_qidx < QI_W'(r_len));

    ned_ref_mem #(
        .DEPTH  (MAX_LENGTH),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_eff_len[ADDR_W-1:0]),
        .i_wr_data (i_in.sample_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_qidx[ADDR_W-1:0]),
        .o_rd_data (w_ref)
    );

    // Operand selection for the shared subtractor: divider step or root step.
    assign w_div_part = {r_rem, r_quo[ACC_W-1]};
    assign w_sq_part  = {r_srem, r_quo[ACC_W-1 -: 2]};

    always_comb begin
        w_alu_a = '0;
        w_alu_b = '0;
        case (r_state)
            S_DIV: begin
                w_alu_a = ALU_W'(w_div_part);
                w_alu_b = ALU_W'(r_len);
            end
            S_SQRT: begin
                w_alu_a = ALU_W'(w_sq_part);
                w_alu_b = ALU_W'({r_root, 2'b01});
            end
            default: begin
                w_alu_a = '0;
                w_alu_b = '0;
            end
        endcase
    end

    ned_sub_unit #(
        .W (ALU_W)
    ) u_sub (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_ge   (w_alu_ge),
        .o_diff (w_alu_diff)
    );

    // Difference against the reference element and its clamped magnitude.
    assign w_diff     = $signed({r_smp[SAMPLE_BITS-1], r_smp})
                      - $signed({w_ref[SAMPLE_BITS-1], w_ref});
    assign w_mag      = w_diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-w_diff)
                                            : (SAMPLE_BITS + 1)'(w_diff);
    assign w_mag_wide = MW'(w_mag);

    // Saturating accumulation of one square.
    assign w_sum     = {1'b0, r_acc} + {1'b0, r_sq};
    assign w_acc_new = (r_big || w_sum[ACC_W]) ? ACC_MAX : w_sum[ACC_W-1:0];

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_restart    = r_restart;
        n_ovf        = r_ovf;
        n_qidx       = r_qidx;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_smp        = r_smp;
        n_last       = r_last;
        n_add_en     = r_add_en;
        n_mag        = r_mag;
        n_big        = r_big;
        n_sq         = r_sq;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_srem       = r_srem;
        n_root       = r_root;
        n_cnt        = r_cnt;
        n_mis        = r_mis;
        n_out_dist   = r_out_dist;
        n_out_status = r_out_status;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.op == OP_LOAD) begin
                        // A load after a closed vector restarts the store.
                        n_ovf = r_restart ? 1'b0 : r_ovf;
                        if (w_eff_len < LEN_CAP) begin
                            n_len = w_eff_len + LEN_W'(1);
                        end else begin
                            n_len = w_eff_len;
                            n_ovf = 1'b1;
                        end
                        n_restart = i_in.is_last;
                    end else begin
                        n_smp    = i_in.sample_value;
                        n_last   = i_in.is_last;
                        n_add_en = w_rd_en;
                        if (r_qidx < QI_MAX) begin
                            n_qidx = r_qidx + QI_W'(1);
                        end
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                // Elements past the stored length contribute nothing.
                n_mag   = r_add_en ? w_mag_wide[MAG_W-1:0] : '0;
                n_big   = r_add_en && (|w_mag_wide[MW-1:MAG_W]);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_sq    = ACC_W'(r_mag) * ACC_W'(r_mag);
                n_state = S_ACC;
            end
            S_ACC: begin
                if (!r_last) begin
                    n_acc   = w_acc_new;
                    n_state = S_IDLE;
                end else begin
                    n_acc  = '0;
                    n_qidx = '0;
                    n_mis  = r_ovf || (r_len == '0) || (r_qidx != QI_W'(r_len));
                    n_quo  = w_acc_new;
                    n_rem  = '0;
                    n_cnt  = CNT_W'(DIV_STEPS - 1);
                    if (r_ovf || (r_len == '0) || (r_qidx != QI_W'(r_len))) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem = w_alu_ge ? w_alu_diff[LEN_W-1:0] : w_div_part[LEN_W-1:0];
                n_quo = {r_quo[ACC_W-2:0], w_alu_ge};
                if (r_cnt == '0) begin
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(SQ_STEPS - 1);
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_SQRT: begin
                // Square-root digit recurrence, one root bit per cycle.
                n_srem = w_alu_ge ? w_alu_diff[ROOT_W-1:0] : w_sq_part[ROOT_W-1:0];
                n_root = {r_root[ROOT_W-2:0], w_alu_ge};
                n_quo  = {r_quo[ACC_W-3:0], 2'b00};
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    if (r_mis) begin
                        n_out_dist   = '0;
                        n_out_status = ST_MISMATCH;
                    end else begin
                        n_out_dist   = (r_root > ROOT_W'(DIST_MAX)) ? DIST_MAX
                                                                    : r_root[DIST_W-1:0];
                        n_out_status = ST_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_restart   <= 1'b1;
            r_ovf       <= 1'b0;
            r_qidx      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_restart   <= n_restart;
            r_ovf       <= n_ovf;
            r_qidx      <= n_qidx;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_smp        <= n_smp;
        r_last       <= n_last;
        r_add_en     <= n_add_en;
        r_mag        <= n_mag;
        r_big        <= n_big;
        r_sq         <= n_sq;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_srem       <= n_srem;
        r_root       <= n_root;
        r_cnt        <= n_cnt;
        r_mis        <= n_mis;
        r_out_dist   <= n_out_dist;
        r_out_status <= n_out_status;
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_out_dist;
    assign o_out.status   = r_out_status;

endmodule

// ----- hw/rtl/ned_ref_mem.sv -----
`timescale 1ns / 1ps

// Reference vector store: one write port, one read port with registered data.
module ned_ref_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered output.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/ned_sub_unit.sv -----
`timescale 1ns / 1ps

// Shared trial subtractor: compares two operands and gives their difference.
// The divider and the square-root recurrence both step through this unit.
module ned_sub_unit #(
    parameter int W = 23
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    logic [W:0] w_sub;

    // The borrow out of the extended subtraction decides a >= b.
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

// ----- hw/rtl/ned_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks for the distance core.
module ned_checker
    import ned_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_op,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DIST_W-1:0] i_out_distance,
    input logic              i_out_status
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_distance) && $stable(i_out_status)))
        else $error("result payload changed while stalled");

    // A mismatch result always carries a zero distance.
    a_mis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status == ST_MISMATCH)) |-> (i_out_distance == '0))
        else $error("mismatch result with nonzero distance");

    // A query transaction occupies the core for the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_op == OP_QUERY)) |=> !i_in_ready)
        else $error("core ready right after a query transaction");

    // A load transaction leaves the core ready in the following cycle.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_op == OP_LOAD)) |=> i_in_ready)
        else $error("core not ready after a load transaction");

endmodule

bind normalized_euclidean_distance_core ned_checker u_ned_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_op        (i_in.op),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_distance (o_out.distance),
    .i_out_status   (o_out.status)
);
